/* hdl/qfr_pkg.sv */
// Package: widths, item types and branch codes of the rotation-matrix-to-quaternion unit.
`default_nettype none
package qfr_pkg;

  localparam int DW   = 16;                   // field width, signed Q2.(DW-2)
  localparam int FB   = DW - 2;               // fraction bits
  localparam int QW   = DW - 1;               // component magnitude width
  localparam int RADW = DW + 2;               // signed radicand width
  localparam int SQ1W = RADW - 1 + FB;        // first root operand width
  localparam int SQ1E = SQ1W + (SQ1W % 2);    // padded to even
  localparam int RT1  = SQ1E / 2;             // first root width
  localparam int SCW  = RT1 + 1;              // scale width
  localparam int NMW  = DW + 1;               // numerator width
  localparam int DVW  = NMW + FB;             // dividend width
  localparam int DCW  = SCW + QW + 1;         // quotient remainder width
  localparam int NW   = 2 * QW + 2;           // squared norm width
  localparam int SQ2E = NW + (NW % 2);
  localparam int RT2  = SQ2E / 2;             // norm root width
  localparam int RW   = 2 * FB + 1;           // reciprocal width
  localparam int RCW  = RT2 + RW;             // reciprocal remainder width

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } qfr_br_t;

  typedef struct packed {
    logic signed [DW-1:0] m00;
    logic signed [DW-1:0] m01;
    logic signed [DW-1:0] m02;
    logic signed [DW-1:0] m10;
    logic signed [DW-1:0] m11;
    logic signed [DW-1:0] m12;
    logic signed [DW-1:0] m20;
    logic signed [DW-1:0] m21;
    logic signed [DW-1:0] m22;
  } qfr_in_t;

  typedef struct packed {
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;
    logic signed [DW-1:0] qz;
    logic signed [DW-1:0] qw;
    logic [1:0]           branch_taken;
  } qfr_out_t;

endpackage
`default_nettype wire

/* hdl/quaternion_from_rotation_matrix_unit.sv */
// Top level: pipelined rotation matrix to unit quaternion converter (trace / largest-diagonal).
//
// Usage: drive in_data with the nine rotation entries and pulse start. An item
// is accepted at every rising edge with start high and busy low; busy is tied
// low, so one item can enter in every cycle and many items are at work at once.
// Each result shows on out_data for exactly one cycle with out_valid high.
// The receiver cannot stall; results leave in the order items came in.
// The pipeline is a chain of digit stages: the first square root (one root
// bit per stage), the quotient divider with four parallel lanes (one quotient
// bit per stage), the norm root and the reciprocal divider (one bit per stage
// each). Throughput: one item per cycle.
// Reset clears every valid bit; items in flight are dropped, payload
// registers keep whatever they held.
// Flow: input register, decode (branch, radicand, numerators), root of the
// radicand, overflow check, restoring division, component assembly, squares,
// norm sum, root of the norm, reciprocal division, final scaling.
`default_nettype none
module quaternion_from_rotation_matrix_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output      logic             busy,
  input  wire qfr_pkg::qfr_in_t in_data,
  output      logic             out_valid,
  output      qfr_pkg::qfr_out_t out_data
);

  localparam int DW   = qfr_pkg::DW;
  localparam int FB   = qfr_pkg::FB;
  localparam int QW   = qfr_pkg::QW;
  localparam int RADW = qfr_pkg::RADW;
  localparam int SQ1E = qfr_pkg::SQ1E;
  localparam int RT1  = qfr_pkg::RT1;
  localparam int SCW  = qfr_pkg::SCW;
  localparam int NMW  = qfr_pkg::NMW;
  localparam int DVW  = qfr_pkg::DVW;
  localparam int DCW  = qfr_pkg::DCW;
  localparam int NW   = qfr_pkg::NW;
  localparam int SQ2E = qfr_pkg::SQ2E;
  localparam int RT2  = qfr_pkg::RT2;
  localparam int RW   = qfr_pkg::RW;
  localparam int RCW  = qfr_pkg::RCW;

  localparam logic signed [RADW-1:0] ONE_R = RADW'(1 << FB);
  localparam logic [QW-1:0]          MAXV  = {QW{1'b1}};

  // payload carried through the first root
  typedef struct packed {
    qfr_pkg::qfr_br_t        br;
    logic [3:0]              sg;
    logic [3:0][NMW-1:0]     mg;
  } p1_t;

  // payload carried through the quotient dividers
  typedef struct packed {
    qfr_pkg::qfr_br_t        br;
    logic [3:0]              sg;
    logic [3:0]              nz;
    logic [3:0]              ovf;
    logic [RT1-1:0]          root;
  } p2_t;

  // payload carried through the norm root and reciprocal
  typedef struct packed {
    qfr_pkg::qfr_br_t        br;
    logic [3:0]              cs;
    logic [3:0][QW-1:0]      cm;
    logic                    eq;
    logic                    zero;
  } p3_t;

  // The receiver never stalls, so the pipeline always advances.
  assign busy = 1'b0;

  // ---------------------------------------------------------------- input
  logic             a_v_r;
  qfr_pkg::qfr_in_t a_m_r;

  // ---------------------------------------------------------------- root 1
  logic [RT1:0]   r1_v_r, r1_v_nxt;
  logic [SQ1E-1:0] r1_op_r   [0:RT1];
  logic [SQ1E-1:0] r1_op_nxt [0:RT1];
  logic [RT1:0]   r1_rem_r   [0:RT1];
  logic [RT1:0]   r1_rem_nxt [0:RT1];
  logic [RT1-1:0] r1_root_r  [0:RT1];
  logic [RT1-1:0] r1_root_nxt[0:RT1];
  p1_t            r1_p_r     [0:RT1];
  p1_t            r1_p_nxt   [0:RT1];

  // ---------------------------------------------------------------- divide
  logic [QW:0]          d_v_r, d_v_nxt;
  logic [3:0][DCW-1:0]  d_rem_r   [0:QW];
  logic [3:0][DCW-1:0]  d_rem_nxt [0:QW];
  logic [3:0][QW-1:0]   d_q_r     [0:QW];
  logic [3:0][QW-1:0]   d_q_nxt   [0:QW];
  logic [SCW-1:0]       d_sc_r    [0:QW];
  logic [SCW-1:0]       d_sc_nxt  [0:QW];
  p2_t                  d_p_r     [0:QW];
  p2_t                  d_p_nxt   [0:QW];

  // ---------------------------------------------------------------- assemble / square
  logic                 e_v_r, e_v_nxt;
  logic [3:0][QW-1:0]   e_cm_r, e_cm_nxt;
  logic [3:0]           e_cs_r, e_cs_nxt;
  qfr_pkg::qfr_br_t     e_br_r, e_br_nxt;

  logic                 f_v_r;
  logic [3:0][2*QW-1:0] f_sq_r;
  logic [3:0][QW-1:0]   f_cm_r;
  logic [3:0]           f_cs_r;
  qfr_pkg::qfr_br_t     f_br_r;

  // ---------------------------------------------------------------- root 2
  logic [RT2:0]    r2_v_r, r2_v_nxt;
  logic [SQ2E-1:0] r2_op_r    [0:RT2];
  logic [SQ2E-1:0] r2_op_nxt  [0:RT2];
  logic [RT2:0]    r2_rem_r   [0:RT2];
  logic [RT2:0]    r2_rem_nxt [0:RT2];
  logic [RT2-1:0]  r2_root_r  [0:RT2];
  logic [RT2-1:0]  r2_root_nxt[0:RT2];
  p3_t             r2_p_r     [0:RT2];
  p3_t             r2_p_nxt   [0:RT2];

  // ---------------------------------------------------------------- reciprocal
  logic [RW:0]     rc_v_r, rc_v_nxt;
  logic [RCW-1:0]  rc_rem_r  [0:RW];
  logic [RCW-1:0]  rc_rem_nxt[0:RW];
  logic [RW-1:0]   rc_q_r    [0:RW];
  logic [RW-1:0]   rc_q_nxt  [0:RW];
  logic [RT2-1:0]  rc_s_r    [0:RW];
  logic [RT2-1:0]  rc_s_nxt  [0:RW];
  p3_t             rc_p_r    [0:RW];
  p3_t             rc_p_nxt  [0:RW];

  // ---------------------------------------------------------------- output
  logic              o_v_r, o_v_nxt;
  qfr_pkg::qfr_out_t o_r, o_nxt;

  // Decode: pick the branch, form the radicand and the signed numerators,
  // then run the digit recurrence of the first root.
  always_comb begin
    logic signed [RADW-1:0] x00, x11, x22, rad;
    logic signed [NMW-1:0]  num [0:3];
    logic [RADW-2:0]        rad_pos;
    logic [RT1+1:0]         cur, trl;
    for (int i = 0; i < 4; i++) begin
      num[i] = '0;
    end
    x00 = RADW'(a_m_r.m00);
    x11 = RADW'(a_m_r.m11);
    x22 = RADW'(a_m_r.m22);
    rad = x00 + x11 + x22 + ONE_R;
    if (rad > 0) begin
      r1_p_nxt[0].br = qfr_pkg::BR_TRACE;
      num[0] = NMW'(a_m_r.m12) - NMW'(a_m_r.m21);
      num[1] = NMW'(a_m_r.m20) - NMW'(a_m_r.m02);
      num[2] = NMW'(a_m_r.m01) - NMW'(a_m_r.m10);
    end else if (a_m_r.m00 > a_m_r.m11 && a_m_r.m00 > a_m_r.m22) begin
      r1_p_nxt[0].br = qfr_pkg::BR_X;
      rad = ONE_R + x00 - x11 - x22;
      num[1] = NMW'(a_m_r.m10) + NMW'(a_m_r.m01);
      num[2] = NMW'(a_m_r.m02) + NMW'(a_m_r.m20);
      num[3] = NMW'(a_m_r.m12) - NMW'(a_m_r.m21);
    end else if (a_m_r.m11 > a_m_r.m22) begin
      r1_p_nxt[0].br = qfr_pkg::BR_Y;
      rad = ONE_R + x11 - x00 - x22;
      num[0] = NMW'(a_m_r.m10) + NMW'(a_m_r.m01);
      num[2] = NMW'(a_m_r.m21) + NMW'(a_m_r.m12);
      num[3] = NMW'(a_m_r.m20) - NMW'(a_m_r.m02);
    end else begin
      r1_p_nxt[0].br = qfr_pkg::BR_Z;
      rad = ONE_R + x22 - x00 - x11;
      num[0] = NMW'(a_m_r.m20) + NMW'(a_m_r.m02);
      num[1] = NMW'(a_m_r.m21) + NMW'(a_m_r.m12);
      num[3] = NMW'(a_m_r.m01) - NMW'(a_m_r.m10);
    end
    // a radicand at or below zero gives a zero scale
    rad_pos = (rad > 0) ? rad[RADW-2:0] : '0;
    for (int i = 0; i < 4; i++) begin
      r1_p_nxt[0].sg[i] = num[i][NMW-1];
      r1_p_nxt[0].mg[i] = num[i][NMW-1] ? NMW'(-num[i]) : NMW'(num[i]);
    end
    r1_v_nxt[0]    = a_v_r;
    r1_op_nxt[0]   = SQ1E'({rad_pos, {FB{1'b0}}});
    r1_rem_nxt[0]  = '0;
    r1_root_nxt[0] = '0;
    // one root bit a stage
    for (int k = 0; k < RT1; k++) begin
      cur = {r1_rem_r[k][RT1-1:0], r1_op_r[k][SQ1E-1-2*k -: 2]};
      trl = {r1_root_r[k], 2'b01};
      r1_v_nxt[k+1]  = r1_v_r[k];
      r1_op_nxt[k+1] = r1_op_r[k];
      r1_p_nxt[k+1]  = r1_p_r[k];
      if (cur >= trl) begin
        r1_rem_nxt[k+1]  = (RT1+1)'(cur - trl);
        r1_root_nxt[k+1] = {r1_root_r[k][RT1-2:0], 1'b1};
      end else begin
        r1_rem_nxt[k+1]  = cur[RT1:0];
        r1_root_nxt[k+1] = {r1_root_r[k][RT1-2:0], 1'b0};
      end
    end
  end

  // Quotients: flag overflow against scale * 2^QW up front, then restore
  // one quotient bit a stage in four lanes.
  always_comb begin
    logic [SCW-1:0] sc;
    logic [DVW-1:0] dv;
    logic [DCW-1:0] t;
    sc = {r1_root_r[RT1], 1'b0};
    d_v_nxt[0]  = r1_v_r[RT1];
    d_sc_nxt[0] = sc;
    d_p_nxt[0].br   = r1_p_r[RT1].br;
    d_p_nxt[0].sg   = r1_p_r[RT1].sg;
    d_p_nxt[0].root = r1_root_r[RT1];
    for (int i = 0; i < 4; i++) begin
      dv = {r1_p_r[RT1].mg[i], {FB{1'b0}}};
      d_p_nxt[0].nz[i]  = (r1_p_r[RT1].mg[i] != '0);
      d_p_nxt[0].ovf[i] = (DCW'(dv) >= (DCW'(sc) << QW));
      d_rem_nxt[0][i]   = DCW'(dv);
      d_q_nxt[0][i]     = '0;
    end
    for (int j = 0; j < QW; j++) begin
      d_v_nxt[j+1]  = d_v_r[j];
      d_sc_nxt[j+1] = d_sc_r[j];
      d_p_nxt[j+1]  = d_p_r[j];
      for (int i = 0; i < 4; i++) begin
        t = DCW'(d_sc_r[j]) << (QW - 1 - j);
        if (d_rem_r[j][i] >= t) begin
          d_rem_nxt[j+1][i] = d_rem_r[j][i] - t;
          d_q_nxt[j+1][i]   = d_q_r[j][i] | (QW'(1) << (QW - 1 - j));
        end else begin
          d_rem_nxt[j+1][i] = d_rem_r[j][i];
          d_q_nxt[j+1][i]   = d_q_r[j][i];
        end
      end
    end
  end

  // Assemble components: the diagonal one is scale/4, saturated; a
  // quotient saturates on overflow and is zero for a zero numerator.
  always_comb begin
    logic [1:0]     di;
    logic [RT1-1:0] h;
    logic [QW-1:0]  hs;
    p2_t            p;
    p = d_p_r[QW];
    case (p.br)
      qfr_pkg::BR_TRACE: di = 2'd3;
      qfr_pkg::BR_X:     di = 2'd0;
      qfr_pkg::BR_Y:     di = 2'd1;
      default:           di = 2'd2;
    endcase
    h  = p.root >> 1;
    hs = (h > RT1'(MAXV)) ? MAXV : QW'(h);
    for (int i = 0; i < 4; i++) begin
      if (2'(i) == di) begin
        e_cm_nxt[i] = hs;
        e_cs_nxt[i] = 1'b0;
      end else begin
        e_cm_nxt[i] = !p.nz[i] ? '0 : (p.ovf[i] ? MAXV : d_q_r[QW][i]);
        e_cs_nxt[i] = p.sg[i];
      end
    end
    e_v_nxt  = d_v_r[QW];
    e_br_nxt = p.br;
  end

  // Norm sum, then the second root, one bit a stage.
  always_comb begin
    logic [NW-1:0]  n;
    logic [RT2+1:0] cur, trl;
    n = NW'(f_sq_r[0]) + NW'(f_sq_r[1]) + NW'(f_sq_r[2]) + NW'(f_sq_r[3]);
    r2_v_nxt[0]       = f_v_r;
    r2_op_nxt[0]      = SQ2E'(n);
    r2_rem_nxt[0]     = '0;
    r2_root_nxt[0]    = '0;
    r2_p_nxt[0].br    = f_br_r;
    r2_p_nxt[0].cs    = f_cs_r;
    r2_p_nxt[0].cm    = f_cm_r;
    r2_p_nxt[0].eq    = (n == (NW'(1) << (2 * FB)));
    r2_p_nxt[0].zero  = 1'b0;
    for (int k = 0; k < RT2; k++) begin
      cur = {r2_rem_r[k][RT2-1:0], r2_op_r[k][SQ2E-1-2*k -: 2]};
      trl = {r2_root_r[k], 2'b01};
      r2_v_nxt[k+1]  = r2_v_r[k];
      r2_op_nxt[k+1] = r2_op_r[k];
      r2_p_nxt[k+1]  = r2_p_r[k];
      if (cur >= trl) begin
        r2_rem_nxt[k+1]  = (RT2+1)'(cur - trl);
        r2_root_nxt[k+1] = {r2_root_r[k][RT2-2:0], 1'b1};
      end else begin
        r2_rem_nxt[k+1]  = cur[RT2:0];
        r2_root_nxt[k+1] = {r2_root_r[k][RT2-2:0], 1'b0};
      end
    end
  end

  // Reciprocal 2^(2*FB) / s, one quotient bit a stage.
  always_comb begin
    logic [RCW-1:0] t;
    rc_v_nxt[0]        = r2_v_r[RT2];
    rc_s_nxt[0]        = r2_root_r[RT2];
    rc_rem_nxt[0]      = RCW'(1) << (2 * FB);
    rc_q_nxt[0]        = '0;
    rc_p_nxt[0]        = r2_p_r[RT2];
    rc_p_nxt[0].zero   = (r2_root_r[RT2] == '0);
    for (int j = 0; j < RW; j++) begin
      t = RCW'(rc_s_r[j]) << (RW - 1 - j);
      rc_v_nxt[j+1] = rc_v_r[j];
      rc_s_nxt[j+1] = rc_s_r[j];
      rc_p_nxt[j+1] = rc_p_r[j];
      if (rc_rem_r[j] >= t) begin
        rc_rem_nxt[j+1] = rc_rem_r[j] - t;
        rc_q_nxt[j+1]   = rc_q_r[j] | (RW'(1) << (RW - 1 - j));
      end else begin
        rc_rem_nxt[j+1] = rc_rem_r[j];
        rc_q_nxt[j+1]   = rc_q_r[j];
      end
    end
  end

  // Final scaling: pass a unit norm unchanged, zero a zero norm, else
  // multiply each magnitude by the reciprocal and restore the sign.
  always_comb begin
    logic [QW+RW-1:0] pr;
    logic [DW-1:0]    v;
    logic [DW-1:0]    c [0:3];
    p3_t              p;
    p = rc_p_r[RW];
    for (int i = 0; i < 4; i++) begin
      pr = (QW+RW)'(p.cm[i]) * (QW+RW)'(rc_q_r[RW]);
      if (p.eq) begin
        v = DW'(p.cm[i]);
      end else if (p.zero) begin
        v = '0;
      end else begin
        v = pr[FB +: DW];
      end
      c[i] = p.cs[i] ? DW'(DW'(0) - v) : v;
    end
    o_v_nxt              = rc_v_r[RW];
    o_nxt.qx             = c[0];
    o_nxt.qy             = c[1];
    o_nxt.qz             = c[2];
    o_nxt.qw             = c[3];
    o_nxt.branch_taken   = p.br;
  end

  // Valid bits: cleared at reset, advance every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      r1_v_r <= '0;
      d_v_r  <= '0;
      e_v_r  <= 1'b0;
      f_v_r  <= 1'b0;
      r2_v_r <= '0;
      rc_v_r <= '0;
      o_v_r  <= 1'b0;
    end else begin
      a_v_r  <= start & ~busy;
      r1_v_r <= r1_v_nxt;
      d_v_r  <= d_v_nxt;
      e_v_r  <= e_v_nxt;
      f_v_r  <= e_v_r;
      r2_v_r <= r2_v_nxt;
      rc_v_r <= rc_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  // Payload: no reset, advance with the valid bits.
  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      a_m_r <= in_data;
    end
    for (int k = 0; k <= RT1; k++) begin
      r1_op_r[k]   <= r1_op_nxt[k];
      r1_rem_r[k]  <= r1_rem_nxt[k];
      r1_root_r[k] <= r1_root_nxt[k];
      r1_p_r[k]    <= r1_p_nxt[k];
    end
    for (int j = 0; j <= QW; j++) begin
      d_rem_r[j] <= d_rem_nxt[j];
      d_q_r[j]   <= d_q_nxt[j];
      d_sc_r[j]  <= d_sc_nxt[j];
      d_p_r[j]   <= d_p_nxt[j];
    end
    e_cm_r <= e_cm_nxt;
    e_cs_r <= e_cs_nxt;
    e_br_r <= e_br_nxt;
    for (int i = 0; i < 4; i++) begin
      f_sq_r[i] <= (2*QW)'(e_cm_r[i]) * (2*QW)'(e_cm_r[i]);
    end
    f_cm_r <= e_cm_r;
    f_cs_r <= e_cs_r;
    f_br_r <= e_br_r;
    for (int k = 0; k <= RT2; k++) begin
      r2_op_r[k]   <= r2_op_nxt[k];
      r2_rem_r[k]  <= r2_rem_nxt[k];
      r2_root_r[k] <= r2_root_nxt[k];
      r2_p_r[k]    <= r2_p_nxt[k];
    end
    for (int j = 0; j <= RW; j++) begin
      rc_rem_r[j] <= rc_rem_nxt[j];
      rc_q_r[j]   <= rc_q_nxt[j];
      rc_s_r[j]   <= rc_s_nxt[j];
      rc_p_r[j]   <= rc_p_nxt[j];
    end
    o_r <= o_nxt;
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

endmodule
`default_nettype wire
